### hw/rtl/mmb_pkg.sv
// Shared types and constants of the model matrix builder.
package mmb_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORD_W         = 34;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [1:0] COL_TRANS = 2'd3;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic                     neg;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic signed [31:0] loc_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } pose_t;

endpackage

### hw/rtl/model_matrix_builder_top.sv
// Top level of the model matrix builder: CORDIC cell chain, rotation stages, column output.
//
// One input beat carries a pose: translation, three binary angles and three scale
// factors. Each pose yields four output beats, columns 0 to 2 of the scaled rotation
// and then column 3 with the translation, which carries last.
// Both channels use valid and ready.
// From the input beat to the first column beat a pose passes 30 CORDIC cells,
// 4 rotation stages, the matrix hold stage and the output register.
// Throughput is set by the four column beats of the output register; the cell
// chain and the rotation stages advance together.
// When the receiver stalls, the output beat holds and the held matrix waits; the whole
// chain stops and in_ready is low whenever a finished matrix waits for the hold stage.
// Reset empties every stage; the block takes a pose in the cycle after reset falls.
module model_matrix_builder_top import mmb_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] loc_x,
  input  logic signed [31:0] loc_y,
  input  logic signed [31:0] loc_z,
  input  logic [ANGLE_BITS-1:0] angle_x,
  input  logic [ANGLE_BITS-1:0] angle_y,
  input  logic [ANGLE_BITS-1:0] angle_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] column,
  output logic signed [31:0] row0,
  output logic signed [31:0] row1,
  output logic signed [31:0] row2,
  output logic [16:0] row3,
  output logic last
);

  logic    adv;
  logic    take;
  logic    chain_valid [CORDIC_STEPS+1];
  cordic_t chain_cord  [CORDIC_STEPS+1][3];
  pose_t   chain_pose  [CORDIC_STEPS+1];
  cordic_t cord_first  [3];
  logic [ANGLE_BITS-1:0] ang [3];
  logic    rot_valid;
  logic signed [FRAC_BITS+3:0] rot [3][3];
  pose_t   rot_pose;

  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  always_comb begin
    logic [31:0] a;
    logic neg;
    for (int k = 0; k < 3; k++) begin
      a = 32'(ang[k]) << (32 - ANGLE_BITS);
      neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      if (neg) a = a - 32'h80000000;
      cord_first[k].x   = CORDIC_GAIN;
      cord_first[k].y   = '0;
      cord_first[k].z   = CORD_W'(signed'(a));
      cord_first[k].neg = neg;
    end
  end

  assign chain_cord[0]  = cord_first;
  assign chain_valid[0] = in_valid;
  assign chain_pose[0]  = '{loc_x: loc_x, loc_y: loc_y, loc_z: loc_z,
                            scale_x: scale_x, scale_y: scale_y, scale_z: scale_z};

  assign adv      = !rot_valid || take;
  assign in_ready = adv;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    mmb_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_cord   (chain_cord[i]),
      .in_pose   (chain_pose[i]),
      .out_valid (chain_valid[i+1]),
      .out_cord  (chain_cord[i+1]),
      .out_pose  (chain_pose[i+1])
    );
  end

  mmb_rotation #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_valid[CORDIC_STEPS]),
    .in_cord   (chain_cord[CORDIC_STEPS]),
    .in_pose   (chain_pose[CORDIC_STEPS]),
    .out_valid (rot_valid),
    .rot       (rot),
    .out_pose  (rot_pose)
  );

  mmb_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .rot       (rot),
    .in_pose   (rot_pose),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .column    (column),
    .row0      (row0),
    .row1      (row1),
    .row2      (row2),
    .row3      (row3),
    .last      (last)
  );

endmodule

### hw/rtl/mmb_cordic_cell.sv
// One CORDIC iteration for the three angles of a pose, with the pose carried along.
module mmb_cordic_cell import mmb_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  cordic_t in_cord [3],
  input  pose_t   in_pose,
  output logic    out_valid,
  output cordic_t out_cord [3],
  output pose_t   out_pose
);

  localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(ATAN_TURN[STEP]);

  cordic_t cord_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cord_next[k].neg = in_cord[k].neg;
      if (!in_cord[k].z[CORD_W-1]) begin
        cord_next[k].x = in_cord[k].x - (in_cord[k].y >>> STEP);
        cord_next[k].y = in_cord[k].y + (in_cord[k].x >>> STEP);
        cord_next[k].z = in_cord[k].z - ATAN;
      end else begin
        cord_next[k].x = in_cord[k].x + (in_cord[k].y >>> STEP);
        cord_next[k].y = in_cord[k].y - (in_cord[k].x >>> STEP);
        cord_next[k].z = in_cord[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cord <= cord_next;
      out_pose <= in_pose;
    end
  end

endmodule

### hw/rtl/mmb_rotation.sv
// Rounds sines and cosines and forms the rotation matrix Rx*Ry*Rz over four stages.
module mmb_rotation import mmb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  cordic_t in_cord [3],
  input  pose_t   in_pose,
  output logic    out_valid,
  output logic signed [FRAC_BITS+3:0] rot [3][3],
  output pose_t   out_pose
);

  localparam int W_T = FRAC_BITS + 3;
  localparam int W_R = FRAC_BITS + 4;
  localparam int SH  = 30 - FRAC_BITS;
  localparam logic signed [CORD_W-1:0] CHALF = CORD_W'(1) <<< (SH - 1);
  localparam logic signed [2*W_T-1:0] PHALF = (2*W_T)'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [W_T-1:0] fm(input logic signed [W_T-1:0] a,
                                               input logic signed [W_T-1:0] b);
    logic signed [2*W_T-1:0] pr;
    pr = (2*W_T)'(a) * (2*W_T)'(b) + PHALF;
    return W_T'(pr >>> FRAC_BITS);
  endfunction

  function automatic logic signed [W_T-1:0] trig(input logic signed [CORD_W-1:0] v,
                                                 input logic neg);
    logic signed [CORD_W-1:0] rv;
    rv = (v + CHALF) >>> SH;
    return neg ? -W_T'(rv) : W_T'(rv);
  endfunction

  logic [3:0] vld;
  pose_t pose_d [4];
  logic signed [W_T-1:0] sn [3];
  logic signed [W_T-1:0] cs [3];
  logic signed [W_T-1:0] p, q, cycz, cxsz, sxsz, cysz, cxcz, sxcz, sxcy, cxcy, sy2;
  logic signed [W_T-1:0] cz3, sz3;
  logic signed [W_T-1:0] pcz, qcz, psz, qsz;
  logic signed [W_T-1:0] cycz3, cxsz3, sxsz3, cysz3, cxcz3, sxcz3, sxcy3, cxcy3, sy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sn[k] <= trig(in_cord[k].y, in_cord[k].neg);
        cs[k] <= trig(in_cord[k].x, in_cord[k].neg);
      end
      pose_d[0] <= in_pose;

      p    <= fm(sn[0], sn[1]);
      q    <= fm(cs[0], sn[1]);
      cycz <= fm(cs[1], cs[2]);
      cxsz <= fm(cs[0], sn[2]);
      sxsz <= fm(sn[0], sn[2]);
      cysz <= fm(cs[1], sn[2]);
      cxcz <= fm(cs[0], cs[2]);
      sxcz <= fm(sn[0], cs[2]);
      sxcy <= fm(sn[0], cs[1]);
      cxcy <= fm(cs[0], cs[1]);
      sy2  <= sn[1];
      cz3  <= cs[2];
      sz3  <= sn[2];
      pose_d[1] <= pose_d[0];

      pcz   <= fm(p, cz3);
      qcz   <= fm(q, cz3);
      psz   <= fm(p, sz3);
      qsz   <= fm(q, sz3);
      cycz3 <= cycz;
      cxsz3 <= cxsz;
      sxsz3 <= sxsz;
      cysz3 <= cysz;
      cxcz3 <= cxcz;
      sxcz3 <= sxcz;
      sxcy3 <= sxcy;
      cxcy3 <= cxcy;
      sy3   <= sy2;
      pose_d[2] <= pose_d[1];

      rot[0][0] <= W_R'(cycz3);
      rot[1][0] <= W_R'(cxsz3) + W_R'(pcz);
      rot[2][0] <= W_R'(sxsz3) - W_R'(qcz);
      rot[0][1] <= -W_R'(cysz3);
      rot[1][1] <= W_R'(cxcz3) - W_R'(psz);
      rot[2][1] <= W_R'(sxcz3) + W_R'(qsz);
      rot[0][2] <= W_R'(sy3);
      rot[1][2] <= -W_R'(sxcy3);
      rot[2][2] <= W_R'(cxcy3);
      pose_d[3] <= pose_d[2];
    end
  end

  assign out_valid = vld[3];
  assign out_pose  = pose_d[3];

endmodule

### hw/rtl/mmb_emit.sv
// Holds one finished matrix and sends it as three scaled column beats and a translation beat.
module mmb_emit import mmb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [FRAC_BITS+3:0] rot [3][3],
  input  pose_t in_pose,
  output logic take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  column,
  output logic signed [31:0] row0,
  output logic signed [31:0] row1,
  output logic signed [31:0] row2,
  output logic [16:0] row3,
  output logic        last
);

  localparam int W_R = FRAC_BITS + 4;
  localparam int PW  = W_R + 32;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< 31) - PW'(1);
  localparam logic signed [PW-1:0] MINV = -(PW'(1) <<< 31);
  localparam logic [16:0] UNITY = 17'(64'd1 << FRAC_BITS);

  function automatic logic signed [31:0] scl(input logic signed [W_R-1:0] r,
                                             input logic signed [31:0] s);
    logic signed [PW-1:0] pr;
    pr = (PW'(r) * PW'(s) + HALF) >>> FRAC_BITS;
    if (pr > MAXV) return 32'sh7FFFFFFF;
    if (pr < MINV) return 32'sh80000000;
    return 32'(pr);
  endfunction

  logic have;
  logic [1:0] cnt;
  logic signed [W_R-1:0] mat [3][3];
  pose_t pose;
  logic load;
  logic signed [31:0] sc;

  assign load = have && (!out_valid || out_ready);
  assign take = !have || (load && cnt == COL_TRANS);

  always_comb begin
    case (cnt)
      2'd0:    sc = pose.scale_x;
      2'd1:    sc = pose.scale_y;
      default: sc = pose.scale_z;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        have <= in_valid;
      end
      if (load) begin
        cnt <= cnt + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      mat  <= rot;
      pose <= in_pose;
    end
    if (load) begin
      column <= cnt;
      if (cnt == COL_TRANS) begin
        row0 <= pose.loc_x;
        row1 <= pose.loc_y;
        row2 <= pose.loc_z;
        row3 <= UNITY;
        last <= 1'b1;
      end else begin
        row0 <= scl(mat[0][cnt], sc);
        row1 <= scl(mat[1][cnt], sc);
        row2 <= scl(mat[2][cnt], sc);
        row3 <= '0;
        last <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/mmb_checker.sv
// Port-level checks of the model matrix builder, bound to its top level.
module mmb_checker import mmb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] column,
  input logic [16:0] row3,
  input logic last
);

  localparam logic [16:0] UNITY = 17'(64'd1 << FRAC_BITS);

  a_last_on_trans: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (column == COL_TRANS))) else $error("last mismatch");

  a_row3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row3 == ((column == COL_TRANS) ? UNITY : 17'd0)))
    else $error("row3 mismatch");

  a_column_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && out_ready) |->
      (column == $past(column) + 2'd1)) else $error("column order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(column)))
    else $error("stalled beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("beat after reset");

endmodule

bind model_matrix_builder_top mmb_checker #(.FRAC_BITS(FRAC_BITS)) u_mmb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .column    (column),
  .row3      (row3),
  .last      (last)
);

### verif/mmb_checker.sv
// Checker that predicts the model matrix of each accepted pose and compares the column beats.
module mmb_scoreboard import mmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic signed [31:0] loc_x,
  input  logic signed [31:0] loc_y,
  input  logic signed [31:0] loc_z,
  input  logic [15:0] angle_x,
  input  logic [15:0] angle_y,
  input  logic [15:0] angle_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [1:0] column,
  input  logic signed [31:0] row0,
  input  logic signed [31:0] row1,
  input  logic signed [31:0] row2,
  input  logic [16:0] row3,
  input  logic last,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] col;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [16:0] r3;
    logic lst;
  } col_beat_t;

  col_beat_t expected_cols[$];

  function automatic longint floor_sr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_sr(a * b + (64'sd1 <<< 15), 16);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  task automatic trig(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic flip;
    longint x, y, z, nx;
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a - 32'h80000000;
    z = longint'(signed'(a));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_sr(y, i);
        y = y + floor_sr(x, i);
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        nx = x + floor_sr(y, i);
        y = y - floor_sr(x, i);
        z = z + longint'(ATAN_TURN[i]);
      end
      x = nx;
    end
    x = floor_sr(x + (64'sd1 <<< 13), 14);
    y = floor_sr(y + (64'sd1 <<< 13), 14);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_matrix();
    longint sx, cx, sy, cy, sz, cz, p, q, sc;
    longint r[3][3];
    col_beat_t b;
    trig(angle_x, sx, cx);
    trig(angle_y, sy, cy);
    trig(angle_z, sz, cz);
    p = qmul(sx, sy);
    q = qmul(cx, sy);
    r[0][0] = qmul(cy, cz);
    r[1][0] = qmul(cx, sz) + qmul(p, cz);
    r[2][0] = qmul(sx, sz) - qmul(q, cz);
    r[0][1] = -qmul(cy, sz);
    r[1][1] = qmul(cx, cz) - qmul(p, sz);
    r[2][1] = qmul(sx, cz) + qmul(q, sz);
    r[0][2] = sy;
    r[1][2] = -qmul(sx, cy);
    r[2][2] = qmul(cx, cy);
    for (int k = 0; k < 3; k++) begin
      sc = (k == 0) ? longint'(scale_x) : (k == 1) ? longint'(scale_y) : longint'(scale_z);
      b.col = k[1:0];
      b.r0 = 32'(clamp32(qmul(r[0][k], sc)));
      b.r1 = 32'(clamp32(qmul(r[1][k], sc)));
      b.r2 = 32'(clamp32(qmul(r[2][k], sc)));
      b.r3 = '0;
      b.lst = 1'b0;
      expected_cols = {expected_cols, b};
    end
    b.col = COL_TRANS;
    b.r0 = loc_x;
    b.r1 = loc_y;
    b.r2 = loc_z;
    b.r3 = 17'h10000;
    b.lst = 1'b1;
    expected_cols = {expected_cols, b};
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    col_beat_t want, got;
    if (!rst) begin
      if (in_valid && in_ready) predict_matrix();
      if (out_valid && out_ready) begin
        got = '{column, row0, row1, row2, row3, last};
        if (expected_cols.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        end else begin
          want = expected_cols.pop_front();
          if (want != got) begin
            errors++;
            $display("%0t: mismatch, expected col=%0d %h %h %h %h last=%b",
                     $time, want.col, want.r0, want.r1, want.r2, want.r3, want.lst);
            $display("%0t:           actual col=%0d %h %h %h %h last=%b",
                     $time, got.col, got.r0, got.r1, got.r2, got.r3, got.lst);
          end
        end
      end
      pending = expected_cols.size();
    end
  end
endmodule

### verif/tb.sv
// Testbench top: drives poses into the model matrix builder and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] loc_x = '0, loc_y = '0, loc_z = '0;
  logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] column;
  logic signed [31:0] row0, row1, row2;
  logic [16:0] row3;
  logic last;
  int errors, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  model_matrix_builder_top dut (.*);
  mmb_scoreboard chk (.*);

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] pick_q(input int mode);
    case (mode)
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00010000;
      3: return 32'hFFFF0000;
      4: return 32'(signed'($urandom_range(0, 32'h00080000)) - 32'sh00040000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pose(input logic [31:0] lx, ly, lz, input logic [15:0] ax, ay, az,
                           input logic [31:0] sx, sy, sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    loc_x <= lx; loc_y <= ly; loc_z <= lz;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    scale_x <= sx; scale_y <= sy; scale_z <= sz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic random_pose();
    send_pose($urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom), 16'($urandom),
              pick_q($urandom_range(6)), pick_q($urandom_range(6)),
              pick_q($urandom_range(6)));
  endtask

  initial begin
    logic [15:0] quads[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_pose(32'h7FFFFFFF, 32'h80000000, '0, '0, '0, '0,
              32'h00010000, 32'h00010000, 32'h00010000);
    send_pose(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++)
      send_pose(32'(i), 32'(-i), 32'h00010000, quads[i], quads[(i + 3) % 8],
                quads[(i + 5) % 8], 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000);
    send_pose('0, '0, '0, 16'h2000, 16'h2000, 16'h2000, '0, '0, '0);
    send_pose(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
              32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 32) : 0;
      recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 32 : 0;
      repeat (30) random_pose();
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end
endmodule
